FILE: sv/ectf_pkg.sv
// ----------------------------------------------------------------------------
// ectf_pkg
// Types, codes and helpers shared by the exon chain trim and filter block.
// ----------------------------------------------------------------------------
package ectf_pkg;

  // Width of the chain count carried by a queued job; covers up to 2047 exons.
  localparam int JOB_CNT_W = 11;
  localparam int EXON_COUNT_W = 7;

  typedef enum logic [2:0] {
    CFG_FILTER_MODE      = 3'd0,
    CFG_TRIM_LENGTH      = 3'd1,
    CFG_MIN_INTRON       = 3'd2,
    CFG_MAX_INTRON       = 3'd3,
    CFG_MAX_EXON         = 3'd4,
    CFG_MIN_EXON         = 3'd5,
    CFG_MIN_CHAIN_LENGTH = 3'd6,
    CFG_MAX_CHAIN_LENGTH = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    VERDICT_KEEP      = 2'd0,
    VERDICT_UNSPLICED = 2'd1,
    VERDICT_LENGTH    = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RD_FIRST,
    BK_RD_LAST,
    BK_TRIM_FIRST,
    BK_TRIM_LAST,
    BK_WALK,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    logic [31:0] exon_start;
    logic [31:0] exon_end;
    logic        last_exon;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              verdict;
    logic [31:0]             chain_first;
    logic [31:0]             chain_last;
    logic [31:0]             chain_length;
    logic [EXON_COUNT_W-1:0] exon_count;
    logic                    overflowed;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  filter_mode;
    logic [15:0] trim_length;
    logic [31:0] min_intron;
    logic [31:0] max_intron;
    logic [31:0] max_exon;
    logic [31:0] min_exon;
    logic [31:0] min_chain_length;
    logic [31:0] max_chain_length;
  } cfg_t;

  // One finished chain waiting for evaluation.
  typedef struct packed {
    logic                 bank;
    logic [JOB_CNT_W-1:0] count;
    logic [31:0]          sum;
    logic                 ovf;
  } job_t;

  // Back end hands a store bank back to the front end.
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  // Exact signed difference of two unsigned positions.
  function automatic logic signed [33:0] sdiff(input logic [31:0] a, input logic [31:0] b);
    sdiff = $signed({2'b00, a}) - $signed({2'b00, b});
  endfunction

  // Unsigned limit seen as a signed value of the same width as sdiff.
  function automatic logic signed [33:0] slim(input logic [31:0] x);
    slim = $signed({2'b00, x});
  endfunction

endpackage

FILE: sv/ectf_ram.sv
// ----------------------------------------------------------------------------
// ectf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ectf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/ectf_front.sv
// ----------------------------------------------------------------------------
// ectf_front
// Accepts exons, writes them to the current store bank, sums their lengths
// and queues a job per finished chain. Two banks alternate between chains.
// ----------------------------------------------------------------------------
module ectf_front #(
  parameter int MAX_EXONS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ectf_pkg::in_item_t         in_data,
  output logic                       wr_en,
  output logic [$clog2(MAX_EXONS):0] wr_addr,
  output logic [63:0]                wr_data,
  output logic                       job_push,
  output ectf_pkg::job_t             job,
  input  logic                       q_full,
  input  ectf_pkg::bank_rel_t        rel
);

  localparam int IDX_W = $clog2(MAX_EXONS);
  localparam int CNT_W = $clog2(MAX_EXONS + 1);

  logic             bank_r, bank_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_upd;
  logic [31:0]      sum_r, sum_nxt, sum_upd;
  logic             ovf_r, ovf_nxt, ovf_upd;
  logic [1:0]       busy_r, busy_nxt;
  logic             accept;
  logic             room;

  assign in_stall = busy_r[bank_r] | q_full;
  assign accept   = in_valid & ~in_stall;
  assign room     = cnt_r < CNT_W'(MAX_EXONS);

  assign wr_en   = accept & room;
  assign wr_addr = {bank_r, cnt_r[IDX_W-1:0]};
  assign wr_data = {in_data.exon_start, in_data.exon_end};

  always_comb begin
    cnt_upd = cnt_r;
    sum_upd = sum_r;
    ovf_upd = ovf_r;
    if (room) begin
      cnt_upd = cnt_r + CNT_W'(1);
      sum_upd = sum_r + (in_data.exon_end - in_data.exon_start + 32'd1);
    end else begin
      ovf_upd = 1'b1;
    end
  end

  assign job_push  = accept & in_data.last_exon;
  assign job.bank  = bank_r;
  assign job.count = ectf_pkg::JOB_CNT_W'(cnt_upd);
  assign job.sum   = sum_upd;
  assign job.ovf   = ovf_upd;

  always_comb begin
    bank_nxt = bank_r;
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    ovf_nxt  = ovf_r;
    busy_nxt = busy_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (accept) begin
      if (in_data.last_exon) begin
        // Hand the bank to the back end and restart on the other one.
        busy_nxt[bank_r] = 1'b1;
        bank_nxt = ~bank_r;
        cnt_nxt  = '0;
        sum_nxt  = '0;
        ovf_nxt  = 1'b0;
      end else begin
        cnt_nxt = cnt_upd;
        sum_nxt = sum_upd;
        ovf_nxt = ovf_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
      cnt_r  <= '0;
      sum_r  <= '0;
      ovf_r  <= 1'b0;
      busy_r <= '0;
    end else begin
      bank_r <= bank_nxt;
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      ovf_r  <= ovf_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

FILE: sv/ectf_job_q.sv
// ----------------------------------------------------------------------------
// ectf_job_q
// Two-entry queue of finished chains between the front and back ends.
// ----------------------------------------------------------------------------
module ectf_job_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ectf_pkg::job_t push_job,
  input  logic           pop,
  output ectf_pkg::job_t head_job,
  output logic           head_valid,
  output logic           full
);

  ectf_pkg::job_t entry_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     fill_r, fill_nxt;
  logic           do_push, do_pop;

  assign head_valid = fill_r != 2'd0;
  assign full       = fill_r == 2'd2;
  assign head_job   = entry_r[rd_ptr_r];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    fill_nxt   = fill_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

FILE: sv/ectf_back.sv
// ----------------------------------------------------------------------------
// ectf_back
// Evaluates one queued chain: reads the end exons, trims them, walks the
// stored exons checking spans and gaps, then registers the result.
// ----------------------------------------------------------------------------
module ectf_back #(
  parameter int MAX_EXONS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ectf_pkg::cfg_t             cfg,
  input  ectf_pkg::job_t             head_job,
  input  logic                       head_valid,
  output logic                       job_pop,
  output logic [$clog2(MAX_EXONS):0] rd_addr,
  input  logic [63:0]                rd_data,
  output ectf_pkg::bank_rel_t        rel,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ectf_pkg::out_item_t        out_data
);

  localparam int IDX_W = $clog2(MAX_EXONS);
  localparam int CNT_W = $clog2(MAX_EXONS + 1);

  ectf_pkg::bk_state_t state_r, state_nxt;
  logic                bank_r, bank_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [31:0]         sum_r, sum_nxt;
  logic                ovf_r, ovf_nxt;
  logic                lo_r, lo_nxt;
  logic [31:0]         f_s_r, f_s_nxt, f_e_r, f_e_nxt;
  logic [31:0]         l_s_r, l_s_nxt, l_e_r, l_e_nxt;
  logic                first_mod_r, first_mod_nxt;
  logic                last_mod_r, last_mod_nxt;
  logic [CNT_W-1:0]    iss_r, iss_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic [CNT_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic [31:0]         prev_e_r, prev_e_nxt;
  logic [31:0]         first_s_r, first_s_nxt;
  logic [31:0]         last_e_r, last_e_nxt;
  logic                fail_r, fail_nxt;
  logic                out_valid_r, out_valid_nxt;
  ectf_pkg::out_item_t out_data_r, out_data_nxt;

  logic [CNT_W-1:0]    hi;
  logic [31:0]         rd_s, rd_e;
  logic [31:0]         eff_s, eff_e;
  logic signed [33:0]  ex, gap;
  logic signed [33:0]  trim_lim;
  logic                is_first, is_last;
  logic                trim_on;
  logic [1:0]          verdict;

  assign hi       = CNT_W'(lo_r) + n_r - CNT_W'(1);
  assign rd_s     = rd_data[63:32];
  assign rd_e     = rd_data[31:0];
  assign trim_lim = ectf_pkg::slim({16'd0, cfg.trim_length});
  assign trim_on  = cfg.trim_length != 16'd0;

  assign is_first = pend_idx_r == CNT_W'(lo_r);
  assign is_last  = pend_idx_r == hi;
  assign eff_s    = (is_first && first_mod_r) ? f_s_r : rd_s;
  assign eff_e    = (is_last && last_mod_r) ? l_e_r : rd_e;
  assign ex       = ectf_pkg::sdiff(eff_e, eff_s) - 34'sd1;
  assign gap      = ectf_pkg::sdiff(eff_s, prev_e_r) - 34'sd1;

  always_comb begin
    if (cfg.filter_mode[0] && n_r == CNT_W'(1)) begin
      verdict = ectf_pkg::VERDICT_UNSPLICED;
    end else if (!cfg.filter_mode[1]) begin
      verdict = ectf_pkg::VERDICT_KEEP;
    end else if (sum_r < cfg.min_chain_length || sum_r > cfg.max_chain_length || fail_r) begin
      verdict = ectf_pkg::VERDICT_LENGTH;
    end else begin
      verdict = ectf_pkg::VERDICT_KEEP;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    bank_nxt      = bank_r;
    n_nxt         = n_r;
    sum_nxt       = sum_r;
    ovf_nxt       = ovf_r;
    lo_nxt        = lo_r;
    f_s_nxt       = f_s_r;
    f_e_nxt       = f_e_r;
    l_s_nxt       = l_s_r;
    l_e_nxt       = l_e_r;
    first_mod_nxt = first_mod_r;
    last_mod_nxt  = last_mod_r;
    iss_nxt       = iss_r;
    pend_vld_nxt  = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    prev_e_nxt    = prev_e_r;
    first_s_nxt   = first_s_r;
    last_e_nxt    = last_e_r;
    fail_nxt      = fail_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & out_stall;
    job_pop       = 1'b0;
    rd_addr       = {bank_r, iss_r[IDX_W-1:0]};
    rel.valid     = 1'b0;
    rel.bank      = bank_r;

    unique case (state_r)
      ectf_pkg::BK_IDLE: begin
        rd_addr = {head_job.bank, IDX_W'(0)};
        if (head_valid) begin
          job_pop       = 1'b1;
          bank_nxt      = head_job.bank;
          n_nxt         = head_job.count[CNT_W-1:0];
          sum_nxt       = head_job.sum;
          ovf_nxt       = head_job.ovf;
          lo_nxt        = 1'b0;
          first_mod_nxt = 1'b0;
          last_mod_nxt  = 1'b0;
          fail_nxt      = 1'b0;
          state_nxt     = ectf_pkg::BK_RD_FIRST;
        end
      end
      ectf_pkg::BK_RD_FIRST: begin
        f_s_nxt   = rd_s;
        f_e_nxt   = rd_e;
        rd_addr   = {bank_r, hi[IDX_W-1:0]};
        state_nxt = ectf_pkg::BK_RD_LAST;
      end
      ectf_pkg::BK_RD_LAST: begin
        l_s_nxt   = rd_s;
        l_e_nxt   = rd_e;
        state_nxt = ectf_pkg::BK_TRIM_FIRST;
      end
      ectf_pkg::BK_TRIM_FIRST: begin
        if (trim_on) begin
          if (ectf_pkg::sdiff(f_e_r, f_s_r) > trim_lim) begin
            f_s_nxt       = f_s_r + {16'd0, cfg.trim_length};
            sum_nxt       = sum_r - {16'd0, cfg.trim_length};
            first_mod_nxt = 1'b1;
            // A single exon is also the last one: carry the new start over.
            if (n_r == CNT_W'(1)) begin
              l_s_nxt = f_s_r + {16'd0, cfg.trim_length};
            end
          end else if (n_r > CNT_W'(1)) begin
            sum_nxt = sum_r - (f_e_r - f_s_r + 32'd1);
            lo_nxt  = 1'b1;
            n_nxt   = n_r - CNT_W'(1);
          end
        end
        state_nxt = ectf_pkg::BK_TRIM_LAST;
      end
      ectf_pkg::BK_TRIM_LAST: begin
        if (trim_on) begin
          if (ectf_pkg::sdiff(l_e_r, l_s_r) > trim_lim) begin
            l_e_nxt      = l_e_r - {16'd0, cfg.trim_length};
            sum_nxt      = sum_r - {16'd0, cfg.trim_length};
            last_mod_nxt = 1'b1;
          end else if (n_r > CNT_W'(1)) begin
            sum_nxt = sum_r - (l_e_r - l_s_r + 32'd1);
            n_nxt   = n_r - CNT_W'(1);
          end
        end
        iss_nxt   = CNT_W'(lo_r);
        state_nxt = ectf_pkg::BK_WALK;
      end
      ectf_pkg::BK_WALK: begin
        // Issue one read a cycle; check the exon whose data arrives.
        if (iss_r <= hi) begin
          rd_addr      = {bank_r, iss_r[IDX_W-1:0]};
          iss_nxt      = iss_r + CNT_W'(1);
          pend_vld_nxt = 1'b1;
          pend_idx_nxt = iss_r;
        end
        if (pend_vld_r) begin
          prev_e_nxt = eff_e;
          if (is_first) begin
            first_s_nxt = eff_s;
            if (n_r > CNT_W'(1) && ex > ectf_pkg::slim(cfg.max_exon)) begin
              fail_nxt = 1'b1;
            end
          end else begin
            if (gap < ectf_pkg::slim(cfg.min_intron) || gap > ectf_pkg::slim(cfg.max_intron) ||
                ex > ectf_pkg::slim(cfg.max_exon) ||
                (ex < ectf_pkg::slim(cfg.min_exon) && !is_last)) begin
              fail_nxt = 1'b1;
            end
          end
          if (is_last) begin
            last_e_nxt   = eff_e;
            pend_vld_nxt = 1'b0;
            state_nxt    = ectf_pkg::BK_DONE;
          end
        end
      end
      ectf_pkg::BK_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.verdict      = verdict;
          out_data_nxt.chain_first  = first_s_r;
          out_data_nxt.chain_last   = last_e_r;
          out_data_nxt.chain_length = sum_r;
          out_data_nxt.exon_count   = ectf_pkg::EXON_COUNT_W'(n_r);
          out_data_nxt.overflowed   = ovf_r;
          rel.valid                 = 1'b1;
          state_nxt                 = ectf_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = ectf_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    bank_r      <= bank_nxt;
    n_r         <= n_nxt;
    sum_r       <= sum_nxt;
    ovf_r       <= ovf_nxt;
    lo_r        <= lo_nxt;
    f_s_r       <= f_s_nxt;
    f_e_r       <= f_e_nxt;
    l_s_r       <= l_s_nxt;
    l_e_r       <= l_e_nxt;
    first_mod_r <= first_mod_nxt;
    last_mod_r  <= last_mod_nxt;
    iss_r       <= iss_nxt;
    pend_idx_r  <= pend_idx_nxt;
    prev_e_r    <= prev_e_nxt;
    first_s_r   <= first_s_nxt;
    last_e_r    <= last_e_nxt;
    fail_r      <= fail_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ectf_pkg::BK_IDLE;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: sv/exon_chain_trim_filter.sv
// ----------------------------------------------------------------------------
// exon_chain_trim_filter
// Stores a transcript's exons, trims the chain ends and filters the chain.
// ----------------------------------------------------------------------------
// Input channel: one exon per transaction (in_valid / in_stall), ascending,
// last_exon set on the final exon of a chain. Exons past MAX_EXONS are
// dropped and reported in the overflowed field.
// Result channel: one transaction per chain (out_valid / out_stall) with the
// verdict, trimmed bounds, length and exon count.
// Configuration: cfg_we writes cfg_wdata into register cfg_index; write only
// while no chain is in flight.
// Throughput: exons are taken one per cycle, while in_stall is low, into one
// of two store banks. The evaluation unit reads the store through one RAM
// port and works on one chain at a time, reading its end exons, trimming
// and walking its kept exons; the front end keeps filling the other bank.
// Reset: clears the chain state, the queue and the output register and loads
// the default limits; the store itself is not cleared.
// A stalled result holds in the output register; with both banks waiting the
// input channel stalls too.
// ----------------------------------------------------------------------------
module exon_chain_trim_filter #(
  parameter int MAX_EXONS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ectf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ectf_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);

  localparam int ADDR_W = $clog2(MAX_EXONS) + 1;

  ectf_pkg::cfg_t      cfg_r, cfg_nxt;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  logic [63:0]         wr_data, rd_data;
  logic                job_push, job_pop, q_full, head_valid;
  ectf_pkg::job_t      push_job, head_job;
  ectf_pkg::bank_rel_t rel;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ectf_pkg::CFG_FILTER_MODE:      cfg_nxt.filter_mode      = cfg_wdata[1:0];
        ectf_pkg::CFG_TRIM_LENGTH:      cfg_nxt.trim_length      = cfg_wdata[15:0];
        ectf_pkg::CFG_MIN_INTRON:       cfg_nxt.min_intron       = cfg_wdata;
        ectf_pkg::CFG_MAX_INTRON:       cfg_nxt.max_intron       = cfg_wdata;
        ectf_pkg::CFG_MAX_EXON:         cfg_nxt.max_exon         = cfg_wdata;
        ectf_pkg::CFG_MIN_EXON:         cfg_nxt.min_exon         = cfg_wdata;
        ectf_pkg::CFG_MIN_CHAIN_LENGTH: cfg_nxt.min_chain_length = cfg_wdata;
        ectf_pkg::CFG_MAX_CHAIN_LENGTH: cfg_nxt.max_chain_length = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_mode      <= 2'd3;
      cfg_r.trim_length      <= 16'd0;
      cfg_r.min_intron       <= 32'd0;
      cfg_r.max_intron       <= 32'hFFFF_FFFF;
      cfg_r.max_exon         <= 32'hFFFF_FFFF;
      cfg_r.min_exon         <= 32'd0;
      cfg_r.min_chain_length <= 32'd0;
      cfg_r.max_chain_length <= 32'hFFFF_FFFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ectf_ram #(
    .WIDTH (64),
    .DEPTH (2 ** ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ectf_front #(
    .MAX_EXONS (MAX_EXONS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .job_push (job_push),
    .job      (push_job),
    .q_full   (q_full),
    .rel      (rel)
  );

  ectf_job_q u_job_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_job   (push_job),
    .pop        (job_pop),
    .head_job   (head_job),
    .head_valid (head_valid),
    .full       (q_full)
  );

  ectf_back #(
    .MAX_EXONS (MAX_EXONS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_job   (head_job),
    .head_valid (head_valid),
    .job_pop    (job_pop),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .rel        (rel),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

FILE: dv/tb_exon_chain_trim_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_exon_chain_trim_filter
// Self-checking bench for the exon chain trim and filter block.
// ----------------------------------------------------------------------------
// Exon chains are sent one exon per transaction. Each accepted exon is folded
// into a local copy of the chain store. On the last exon the bench trims,
// judges and queues the expected chain report. Every report from the block is
// compared field by field with the oldest queued one. Directed chains cover
// trimming, the unspliced rule, each length limit, reversed and overlapping
// exons and a full store. Random phases then run with fresh limits each time,
// random idling on both channels and one phase with no idling at all.
// ----------------------------------------------------------------------------
module tb_exon_chain_trim_filter;

  localparam int          STORE_DEPTH  = 64;
  localparam int          RANDOM_ITEMS = 1500;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          SETTLE_WAIT  = 100;

  localparam ectf_pkg::cfg_t RESET_LIMITS = '{
    filter_mode:      2'd3,
    trim_length:      16'd0,
    min_intron:       32'd0,
    max_intron:       32'hFFFF_FFFF,
    max_exon:         32'hFFFF_FFFF,
    min_exon:         32'd0,
    min_chain_length: 32'd0,
    max_chain_length: 32'hFFFF_FFFF
  };

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  ectf_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ectf_pkg::out_item_t out_data;
  logic                cfg_we    = 1'b0;
  logic [2:0]          cfg_index = '0;
  logic [31:0]         cfg_wdata = '0;

  // local copy of the block state
  ectf_pkg::cfg_t      limits = RESET_LIMITS;
  logic [31:0]         kept_start [STORE_DEPTH];
  logic [31:0]         kept_end   [STORE_DEPTH];
  int unsigned         kept_count = 0;
  logic [31:0]         span_total = '0;
  bit                  spilled    = 1'b0;

  ectf_pkg::out_item_t chain_reports [$];
  int unsigned         mismatches = 0;
  int unsigned         items_sent = 0;
  int unsigned         cycles     = 0;
  bit                  calm       = 1'b0;

  exon_chain_trim_filter #(.MAX_EXONS(STORE_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 28);
    end
  end

  // Fold one accepted exon into the chain; on the last exon trim, judge and
  // queue the report.
  task automatic fold_exon(input ectf_pkg::in_item_t x);
    logic [31:0]         t;
    int unsigned         k;
    int unsigned         j;
    longint              gap;
    longint              ex;
    ectf_pkg::verdict_t  verdict;
    ectf_pkg::out_item_t rep;
    if (kept_count < STORE_DEPTH) begin
      kept_start[kept_count] = x.exon_start;
      kept_end[kept_count]   = x.exon_end;
      kept_count++;
      span_total = span_total + (x.exon_end - x.exon_start + 32'd1);
    end else begin
      spilled = 1'b1;
    end
    if (!x.last_exon) return;

    t = {16'd0, limits.trim_length};
    if (t != 0) begin
      if (longint'(kept_end[0]) - longint'(kept_start[0]) > longint'(t)) begin
        kept_start[0] = kept_start[0] + t;
        span_total    = span_total - t;
      end else if (kept_count > 1) begin
        span_total = span_total - (kept_end[0] - kept_start[0] + 32'd1);
        for (k = 0; k < kept_count - 1; k++) begin
          kept_start[k] = kept_start[k + 1];
          kept_end[k]   = kept_end[k + 1];
        end
        kept_count--;
      end
      // a lone exon gets the second cut here as well
      k = kept_count - 1;
      if (longint'(kept_end[k]) - longint'(kept_start[k]) > longint'(t)) begin
        kept_end[k] = kept_end[k] - t;
        span_total  = span_total - t;
      end else if (kept_count > 1) begin
        span_total = span_total - (kept_end[k] - kept_start[k] + 32'd1);
        kept_count--;
      end
    end

    verdict = ectf_pkg::VERDICT_KEEP;
    if (limits.filter_mode[0] && kept_count == 1) begin
      verdict = ectf_pkg::VERDICT_UNSPLICED;
    end else if (limits.filter_mode[1]) begin
      if (span_total < limits.min_chain_length || span_total > limits.max_chain_length) begin
        verdict = ectf_pkg::VERDICT_LENGTH;
      end else if (kept_count > 1 && longint'(kept_end[0]) - longint'(kept_start[0]) - 1 >
                   longint'(limits.max_exon)) begin
        verdict = ectf_pkg::VERDICT_LENGTH;
      end else begin
        for (j = 1; j < kept_count && verdict == ectf_pkg::VERDICT_KEEP; j++) begin
          gap = longint'(kept_start[j]) - longint'(kept_end[j - 1]) - 1;
          ex  = longint'(kept_end[j]) - longint'(kept_start[j]) - 1;
          if (gap < longint'(limits.min_intron) || gap > longint'(limits.max_intron))
            verdict = ectf_pkg::VERDICT_LENGTH;
          else if (ex > longint'(limits.max_exon))
            verdict = ectf_pkg::VERDICT_LENGTH;
          else if (ex < longint'(limits.min_exon) && j < kept_count - 1)
            verdict = ectf_pkg::VERDICT_LENGTH;
        end
      end
    end

    rep.verdict      = verdict;
    rep.chain_first  = kept_start[0];
    rep.chain_last   = kept_end[kept_count - 1];
    rep.chain_length = span_total;
    rep.exon_count   = kept_count[ectf_pkg::EXON_COUNT_W-1:0];
    rep.overflowed   = spilled;
    chain_reports    = {chain_reports, rep};
    kept_count = 0;
    span_total = '0;
    spilled    = 1'b0;
  endtask

  task automatic send_exon(input logic [31:0] s, input logic [31:0] e, input bit last);
    ectf_pkg::in_item_t x;
    x = '{exon_start: s, exon_end: e, last_exon: last};
    while (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    // inputs only move at the rising edge, so the stall seen here holds to it
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    fold_exon(x);
    items_sent++;
  endtask

  // Drop valid, wait for every queued report, then let the block go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (chain_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic apply_limits(input ectf_pkg::cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= ectf_pkg::CFG_FILTER_MODE;
    cfg_wdata <= 32'(c.filter_mode);
    @(posedge clk);
    cfg_index <= ectf_pkg::CFG_TRIM_LENGTH;
    cfg_wdata <= 32'(c.trim_length);
    @(posedge clk);
    cfg_index <= ectf_pkg::CFG_MIN_INTRON;
    cfg_wdata <= c.min_intron;
    @(posedge clk);
    cfg_index <= ectf_pkg::CFG_MAX_INTRON;
    cfg_wdata <= c.max_intron;
    @(posedge clk);
    cfg_index <= ectf_pkg::CFG_MAX_EXON;
    cfg_wdata <= c.max_exon;
    @(posedge clk);
    cfg_index <= ectf_pkg::CFG_MIN_EXON;
    cfg_wdata <= c.min_exon;
    @(posedge clk);
    cfg_index <= ectf_pkg::CFG_MIN_CHAIN_LENGTH;
    cfg_wdata <= c.min_chain_length;
    @(posedge clk);
    cfg_index <= ectf_pkg::CFG_MAX_CHAIN_LENGTH;
    cfg_wdata <= c.max_chain_length;
    @(posedge clk);
    cfg_we <= 1'b0;
    limits = c;
  endtask

  // Ascending chain with random exon sizes and introns; rough chains mix in
  // exons with arbitrary bounds.
  task automatic send_random_chain(input int n, input bit rough);
    logic [31:0] s;
    logic [31:0] e;
    int unsigned len;
    int unsigned pick;
    case ($urandom_range(9))
      0:       s = $urandom();
      1:       s = 32'hFFFF_F000 + $urandom_range(0, 4095);
      default: s = $urandom_range(0, 200000);
    endcase
    for (int k = 0; k < n; k++) begin
      if (rough && $urandom_range(7) == 0) begin
        s = $urandom();
        e = $urandom();
      end else begin
        pick = $urandom_range(9);
        if (pick < 2)      len = $urandom_range(0, 12);
        else if (pick < 9) len = $urandom_range(13, 400);
        else               len = $urandom_range(401, 5000);
        e = s + len;
      end
      send_exon(s, e, k == n - 1);
      pick = $urandom_range(19);
      if (pick == 0)      s = e - $urandom_range(0, 60);
      else if (pick == 1) s = e + 1;
      else                s = e + 1 + $urandom_range(0, 2000);
    end
  endtask

  task automatic random_limits();
    ectf_pkg::cfg_t c;
    c.filter_mode = 2'($urandom_range(0, 3));
    case ($urandom_range(4))
      0:       c.trim_length = 16'd0;
      1:       c.trim_length = 16'hFFFF;
      2:       c.trim_length = 16'($urandom());
      default: c.trim_length = 16'($urandom_range(1, 300));
    endcase
    c.min_intron       = ($urandom_range(5) == 0) ? $urandom() : $urandom_range(0, 100);
    c.max_intron       = ($urandom_range(5) == 0) ? 32'hFFFF_FFFF : $urandom_range(500, 3000);
    c.max_exon         = ($urandom_range(5) == 0) ? 32'hFFFF_FFFF : $urandom_range(100, 600);
    c.min_exon         = ($urandom_range(5) == 0) ? $urandom() : $urandom_range(0, 60);
    c.min_chain_length = $urandom_range(0, 500);
    c.max_chain_length = ($urandom_range(5) == 0) ? $urandom() : $urandom_range(500, 6000);
    apply_limits(c);
  endtask

  task automatic test_reset_limits();
    send_exon(32'd0, 32'hFFFF_FFFF, 1'b1);
    send_exon(32'd100, 32'd199, 1'b0);
    send_exon(32'd300, 32'd399, 1'b1);
    send_exon(32'd500, 32'd400, 1'b0);
    send_exon(32'd600, 32'd700, 1'b1);
    settle();
  endtask

  task automatic test_end_trimming();
    ectf_pkg::cfg_t c;
    c = RESET_LIMITS;
    c.filter_mode = 2'd2;
    c.trim_length = 16'd10;
    apply_limits(c);
    send_exon(32'd1000, 32'd1100, 1'b1);
    // too short to cut and the only exon, so it stays whole
    send_exon(32'd1000, 32'd1005, 1'b1);
    send_exon(32'd0, 32'd5, 1'b0);
    send_exon(32'd100, 32'd200, 1'b0);
    send_exon(32'd300, 32'd303, 1'b1);
    // span equal to the trim length removes the exon
    send_exon(32'd0, 32'd10, 1'b0);
    send_exon(32'd50, 32'd150, 1'b1);
    send_exon(32'd200, 32'd300, 1'b0);
    send_exon(32'd400, 32'd500, 1'b1);
    settle();
  endtask

  task automatic test_length_limits();
    ectf_pkg::cfg_t c;
    c = '{filter_mode: 2'd2, trim_length: 16'd0, min_intron: 32'd100, max_intron: 32'd1000,
          max_exon: 32'd200, min_exon: 32'd50, min_chain_length: 32'd10,
          max_chain_length: 32'd1000};
    apply_limits(c);
    send_exon(32'd0, 32'd99, 1'b0);
    send_exon(32'd200, 32'd299, 1'b0);
    send_exon(32'd400, 32'd409, 1'b1);
    send_exon(32'd0, 32'd99, 1'b0);
    send_exon(32'd150, 32'd249, 1'b1);
    // overlap gives a negative intron
    send_exon(32'd0, 32'd99, 1'b0);
    send_exon(32'd50, 32'd149, 1'b1);
    send_exon(32'd0, 32'd1500, 1'b1);
    send_exon(32'd0, 32'd300, 1'b0);
    send_exon(32'd500, 32'd520, 1'b1);
    settle();
  endtask

  task automatic test_extreme_limits();
    ectf_pkg::cfg_t c;
    c = '{filter_mode: 2'd3, trim_length: 16'hFFFF, min_intron: 32'hFFFF_FFFF,
          max_intron: 32'd0, max_exon: 32'd0, min_exon: 32'hFFFF_FFFF,
          min_chain_length: 32'hFFFF_FFFF, max_chain_length: 32'd0};
    apply_limits(c);
    send_exon(32'd0, 32'hFFFF_FFFF, 1'b1);
    send_exon(32'd0, 32'd100, 1'b0);
    send_exon(32'h1000_0000, 32'hFFFF_FFFF, 1'b1);
    // let the chains drain before the limits change
    settle();
    c.filter_mode      = 2'd2;
    c.min_chain_length = 32'd0;
    c.max_chain_length = 32'hFFFF_FFFF;
    apply_limits(c);
    send_exon(32'd0, 32'h0010_0000, 1'b0);
    send_exon(32'h0020_0000, 32'h0030_0000, 1'b1);
    settle();
  endtask

  task automatic test_store_full();
    ectf_pkg::cfg_t c;
    c = RESET_LIMITS;
    c.trim_length = 16'd5;
    apply_limits(c);
    send_random_chain(STORE_DEPTH, 1'b0);
    // the final exon lands on a full store and is dropped
    send_random_chain(STORE_DEPTH + 1, 1'b0);
    send_random_chain($urandom_range(STORE_DEPTH + 2, STORE_DEPTH + 30), 1'b1);
    settle();
  endtask

  task automatic test_random_chains();
    int unsigned target;
    int unsigned phase_mark;
    int          phase;
    int          n;
    target = items_sent + RANDOM_ITEMS;
    phase  = 0;
    while (items_sent < target) begin
      random_limits();
      calm       = (phase == 2);
      phase_mark = items_sent;
      while (items_sent - phase_mark < 250 && items_sent < target) begin
        case ($urandom_range(19))
          0:       n = $urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 8);
          1, 2:    n = $urandom_range(9, 30);
          default: n = $urandom_range(1, 8);
        endcase
        send_random_chain(n, $urandom_range(4) == 0);
      end
      settle();
      calm = 1'b0;
      phase++;
    end
  endtask

  always @(negedge clk) begin
    ectf_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (chain_reports.size() == 0) begin
        $display("%0t: unexpected chain report %h", $time, out_data);
        mismatches++;
      end else begin
        want = chain_reports.pop_front();
        if (out_data.verdict !== want.verdict) begin
          $display("%0t: verdict expected %0d, got %0d", $time, want.verdict,
                   out_data.verdict);
          mismatches++;
        end
        if (out_data.chain_first !== want.chain_first) begin
          $display("%0t: chain_first expected %h, got %h", $time, want.chain_first,
                   out_data.chain_first);
          mismatches++;
        end
        if (out_data.chain_last !== want.chain_last) begin
          $display("%0t: chain_last expected %h, got %h", $time, want.chain_last,
                   out_data.chain_last);
          mismatches++;
        end
        if (out_data.chain_length !== want.chain_length) begin
          $display("%0t: chain_length expected %h, got %h", $time, want.chain_length,
                   out_data.chain_length);
          mismatches++;
        end
        if (out_data.exon_count !== want.exon_count) begin
          $display("%0t: exon_count expected %0d, got %0d", $time, want.exon_count,
                   out_data.exon_count);
          mismatches++;
        end
        if (out_data.overflowed !== want.overflowed) begin
          $display("%0t: overflowed expected %0d, got %0d", $time, want.overflowed,
                   out_data.overflowed);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_limits();
    test_end_trimming();
    test_length_limits();
    test_extreme_limits();
    test_store_full();
    test_random_chains();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
